>>> rtl/core/deq_pkg.sv
// Shared types and constants for the double-ended queue engine.
`timescale 1ns / 1ps

package deq_pkg;

   // Fixed field widths of the request and response beats
   localparam int FUNC_W      = 3;
   localparam int PUSH_W      = 32;
   localparam int SLOT_W      = 8;
   localparam int ELEM_OUT_W  = 32;
   localparam int COUNT_W     = 9;
   localparam int STATUS_W    = 2;
   localparam int START_W     = 2;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ_SLOT  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_REINIT     = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE = 2'd3;

   // Start position codes (anything else behaves as middle)
   localparam logic [START_W-1:0] START_BEGIN  = 2'd0;
   localparam logic [START_W-1:0] START_MIDDLE = 2'd1;
   localparam logic [START_W-1:0] START_END    = 2'd2;

   // Depth of the result queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [PUSH_W-1:0] push_value;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [ELEM_OUT_W-1:0] element_out;
      logic [COUNT_W-1:0]    live_count;
      logic                  is_empty;
      logic [STATUS_W-1:0]   status;
   } rsp_type;

   // Descriptor carried alongside the store read
   typedef struct packed {
      logic                rd_hit;
      logic [COUNT_W-1:0]  live_count;
      logic                is_empty;
      logic [STATUS_W-1:0] status;
   } meta_type;

endpackage

>>> rtl/core/double_ended_queue_engine_core.sv
// Top level of the double-ended queue engine.
`timescale 1ns / 1ps
// Double-ended queue over a store of CAPACITY slots of ELEMENT_WIDTH bits.
// Request beats (req_valid / req_stall / req_data) carry one operation each:
// push front, push back, pop front, pop back, read slot or re-initialise.
// Every request yields exactly one response beat (rsp_valid / rsp_stall /
// rsp_data) with the element, live count, empty flag and status, in order.
// csr_wr_en / csr_wr_data set the start position used at re-initialise.
// A response passes from the store read stage through the result queue to
// the output register. Throughput: one operation per cycle while req_stall
// is low, set by the single store write port and single store read port,
// both used by the front end.
// A four-beat result queue sits between the front end and the output
// register; while the receiver stalls the queue fills and req_stall rises
// once it (plus the beat in the read stage) is full.
// Reset empties the queue, places the pointers at the middle of the store
// and sets the start position to middle; the store contents are not cleared
// and no clearing pass is needed, since only live slots are ever read.
module double_ended_queue_engine_core #(
   parameter int CAPACITY      = 256,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  deq_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output deq_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [deq_pkg::START_W-1:0] csr_wr_data
);

   logic                          q_push, q_pop, q_not_empty;
   deq_pkg::rsp_type              q_push_data, q_head_data;
   logic [deq_pkg::QUEUE_LW-1:0]  q_level;

   // Front end and slot store
   deq_front #(
      .CAPACITY      (CAPACITY),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_level     (q_level),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // Result queue
   deq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (q_head_data),
      .level     (q_level)
   );

   // Output stage
   deq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head_data (q_head_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

>>> rtl/core/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

>>> rtl/core/deq_front.sv
// Front end: accepts requests, checks pointers, drives the slot store.
`timescale 1ns / 1ps

module deq_front #(
   parameter int CAPACITY      = 256,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  deq_pkg::req_type                    req_data,
   input  logic                                csr_wr_en,
   input  logic [deq_pkg::START_W-1:0]         csr_wr_data,
   input  logic [deq_pkg::QUEUE_LW-1:0]        q_level,
   output logic                                q_push,
   output deq_pkg::rsp_type                    q_push_data
);

   localparam int AW  = $clog2(CAPACITY);
   localparam int PW  = $clog2(CAPACITY + 1);
   localparam int CW  = (PW > deq_pkg::SLOT_W) ? PW : deq_pkg::SLOT_W;
   localparam int XW  = (PW > deq_pkg::COUNT_W) ? PW : deq_pkg::COUNT_W;
   localparam int EXW = (ELEMENT_WIDTH > deq_pkg::ELEM_OUT_W) ?
                        ELEMENT_WIDTH : deq_pkg::ELEM_OUT_W;
   localparam int QLW = deq_pkg::QUEUE_LW;

   localparam logic [PW-1:0] PTR_BEGIN  = PW'(1);
   localparam logic [PW-1:0] PTR_MIDDLE = PW'(CAPACITY / 2);
   localparam logic [PW-1:0] PTR_END    = PW'(CAPACITY);

   logic [deq_pkg::START_W-1:0] start_position_ff;
   logic [PW-1:0]               bp_ff, bp_in, fp_ff, fp_in;
   logic [PW-1:0]               bp_op, fp_op, start_ptr;
   logic                        accept;
   logic                        empty_now;
   logic [CW-1:0]               idx_ext, bp_ext, fp_ext;
   logic [PW-1:0]               cnt;
   logic [XW-1:0]               cnt_ext;
   logic [EXW-1:0]              push_ext, rd_ext;
   logic                        wr_op, rd_op;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic [ELEMENT_WIDTH-1:0]    rd_data;
   logic [deq_pkg::STATUS_W-1:0] status;
   logic                        s1_valid_ff, s1_valid_in;
   deq_pkg::meta_type           s1_meta_ff;

   // Occupancy seen by the queue, counting the beat still in the read stage
   assign req_stall = ({1'b0, q_level} + (QLW + 1)'(s1_valid_ff)) >=
                      (QLW + 1)'(deq_pkg::QUEUE_DEPTH);
   assign accept    = req_valid & ~req_stall;

   // Start position register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_position_ff <= deq_pkg::START_MIDDLE;
      end else if (csr_wr_en) begin
         start_position_ff <= csr_wr_data;
      end
   end

   always_comb begin
      case (start_position_ff)
         deq_pkg::START_BEGIN: start_ptr = PTR_BEGIN;
         deq_pkg::START_END:   start_ptr = PTR_END;
         default:              start_ptr = PTR_MIDDLE;
      endcase
   end

   assign empty_now = (fp_ff == bp_ff);
   assign idx_ext   = CW'(req_data.slot_index);
   assign bp_ext    = CW'(bp_ff);
   assign fp_ext    = CW'(fp_ff);

   // Operation decode and pointer checks
   always_comb begin
      bp_op   = bp_ff;
      fp_op   = fp_ff;
      wr_op   = 1'b0;
      rd_op   = 1'b0;
      wr_addr = fp_ff[AW-1:0];
      rd_addr = bp_ff[AW-1:0];
      status  = deq_pkg::STATUS_OK;
      unique case (req_data.func)
         deq_pkg::FUNC_PUSH_FRONT: begin
            if (fp_ff == PTR_END) begin
               status = deq_pkg::STATUS_FULL;
            end else begin
               wr_op   = 1'b1;
               wr_addr = fp_ff[AW-1:0];
               fp_op   = fp_ff + PW'(1);
            end
         end
         deq_pkg::FUNC_PUSH_BACK: begin
            if (bp_ff == '0) begin
               status = deq_pkg::STATUS_FULL;
            end else begin
               bp_op   = bp_ff - PW'(1);
               wr_op   = 1'b1;
               wr_addr = bp_op[AW-1:0];
            end
         end
         deq_pkg::FUNC_POP_FRONT: begin
            if (empty_now) begin
               status = deq_pkg::STATUS_EMPTY;
            end else begin
               fp_op   = fp_ff - PW'(1);
               rd_op   = 1'b1;
               rd_addr = fp_op[AW-1:0];
            end
         end
         deq_pkg::FUNC_POP_BACK: begin
            if (empty_now) begin
               status = deq_pkg::STATUS_EMPTY;
            end else begin
               rd_op   = 1'b1;
               rd_addr = bp_ff[AW-1:0];
               bp_op   = bp_ff + PW'(1);
            end
         end
         deq_pkg::FUNC_READ_SLOT: begin
            if (idx_ext < bp_ext || idx_ext >= fp_ext || idx_ext >= CW'(CAPACITY)) begin
               status = deq_pkg::STATUS_OUT_RANGE;
            end else begin
               rd_op   = 1'b1;
               rd_addr = idx_ext[AW-1:0];
            end
         end
         deq_pkg::FUNC_REINIT: begin
            bp_op = start_ptr;
            fp_op = start_ptr;
         end
         default: begin
         end
      endcase
   end

   assign bp_in = accept ? bp_op : bp_ff;
   assign fp_in = accept ? fp_op : fp_ff;

   // Pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bp_ff <= PTR_MIDDLE;
         fp_ff <= PTR_MIDDLE;
      end else begin
         bp_ff <= bp_in;
         fp_ff <= fp_in;
      end
   end

   // Slot store
   assign push_ext = EXW'(req_data.push_value);

   deq_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock      (clock),
      .wr_en      (accept & wr_op),
      .wr_addr    (wr_addr),
      .wr_data    (push_ext[ELEMENT_WIDTH-1:0]),
      .rd_en      (accept & rd_op),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // Read stage: descriptor waits for the store read data
   assign cnt         = fp_op - bp_op;
   assign cnt_ext     = XW'(cnt);
   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff.rd_hit     <= rd_op;
         s1_meta_ff.live_count <= cnt_ext[deq_pkg::COUNT_W-1:0];
         s1_meta_ff.is_empty   <= (cnt == '0);
         s1_meta_ff.status     <= status;
      end
   end

   // Assemble the result beat for the queue
   assign rd_ext = EXW'(rd_data);

   always_comb begin
      q_push                  = s1_valid_ff;
      q_push_data.element_out = s1_meta_ff.rd_hit ? rd_ext[deq_pkg::ELEM_OUT_W-1:0] : '0;
      q_push_data.live_count  = s1_meta_ff.live_count;
      q_push_data.is_empty    = s1_meta_ff.is_empty;
      q_push_data.status      = s1_meta_ff.status;
   end

endmodule

>>> rtl/core/deq_queue.sv
// Short result queue decoupling the front end from the output stage.
`timescale 1ns / 1ps

module deq_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  deq_pkg::rsp_type              push_data,
   input  logic                          pop,
   output logic                          not_empty,
   output deq_pkg::rsp_type              head_data,
   output logic [deq_pkg::QUEUE_LW-1:0]  level
);

   localparam int QAW = deq_pkg::QUEUE_AW;
   localparam int QLW = deq_pkg::QUEUE_LW;
   localparam logic [QAW-1:0] LAST = QAW'(deq_pkg::QUEUE_DEPTH - 1);

   deq_pkg::rsp_type  entry_ff [deq_pkg::QUEUE_DEPTH];
   logic [QAW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [QLW-1:0]    level_ff, level_in;
   logic              do_pop;

   assign do_pop    = pop & (level_ff != '0);
   assign not_empty = (level_ff != '0);
   assign head_data = entry_ff[head_ff];
   assign level     = level_ff;

   // Pointer and level update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      level_in = level_ff;
      if (push) begin
         tail_in = (tail_ff == LAST) ? '0 : tail_ff + QAW'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == LAST) ? '0 : head_ff + QAW'(1);
      end
      case ({push, do_pop})
         2'b10:   level_in = level_ff + QLW'(1);
         2'b01:   level_in = level_ff - QLW'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/deq_back.sv
// Back end: output register presenting result beats to the receiver.
`timescale 1ns / 1ps

module deq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  deq_pkg::rsp_type  q_head_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output deq_pkg::rsp_type  rsp_data
);

   logic             rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type rsp_data_ff;
   logic             load;

   // Reload when empty or when the current beat is taken
   assign load         = ~rsp_valid_ff | ~rsp_stall;
   assign q_pop        = load & q_not_empty;
   assign rsp_valid_in = load ? q_not_empty : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= q_head_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
